### src/pcir_pkg.sv
`default_nettype none

package pcir_pkg;

    localparam int COUNT_BITS    = 17;
    localparam int FIRST_DIVISOR = 2;
    localparam int PC_BITS       = 4;

    typedef logic [PC_BITS-1:0] t_pc;

    // program step addresses
    localparam t_pc S_WAIT_IN   = 4'd0;
    localparam t_pc S_CHK_RANGE = 4'd1;
    localparam t_pc S_CAND_INIT = 4'd2;
    localparam t_pc S_TRIAL_CHK = 4'd3;
    localparam t_pc S_DIV_START = 4'd4;
    localparam t_pc S_DIV_WAIT  = 4'd5;
    localparam t_pc S_REM_CHK   = 4'd6;
    localparam t_pc S_TRIAL_LP  = 4'd7;
    localparam t_pc S_PRIME     = 4'd8;
    localparam t_pc S_NEXT_CAND = 4'd9;
    localparam t_pc S_CAND_LP   = 4'd10;
    localparam t_pc S_EMIT_WAIT = 4'd11;
    localparam t_pc S_EMIT      = 4'd12;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_CAND_INIT,
        OP_DIV_START,
        OP_D_INC,
        OP_CNT_INC,
        OP_V_INC,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NOT_IN_VALID,
        C_EMPTY,
        C_LT_TWO,
        C_SQ_GT,
        C_DIV_BUSY,
        C_REM_ZERO,
        C_AT_HI,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic empty;
        logic lt_two;
        logic sq_gt;
        logic div_busy;
        logic rem_zero;
        logic at_hi;
        logic out_busy;
    } t_status;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: S_WAIT_IN};
        case (pc)
            S_WAIT_IN:   w = '{op: OP_LOAD,      cond: C_NOT_IN_VALID, target: S_WAIT_IN};
            S_CHK_RANGE: w = '{op: OP_NOP,       cond: C_EMPTY,        target: S_EMIT_WAIT};
            S_CAND_INIT: w = '{op: OP_CAND_INIT, cond: C_LT_TWO,       target: S_NEXT_CAND};
            S_TRIAL_CHK: w = '{op: OP_NOP,       cond: C_SQ_GT,        target: S_PRIME};
            S_DIV_START: w = '{op: OP_DIV_START, cond: C_NONE,         target: S_WAIT_IN};
            S_DIV_WAIT:  w = '{op: OP_NOP,       cond: C_DIV_BUSY,     target: S_DIV_WAIT};
            S_REM_CHK:   w = '{op: OP_D_INC,     cond: C_REM_ZERO,     target: S_NEXT_CAND};
            S_TRIAL_LP:  w = '{op: OP_NOP,       cond: C_ALWAYS,       target: S_TRIAL_CHK};
            S_PRIME:     w = '{op: OP_CNT_INC,   cond: C_NONE,         target: S_WAIT_IN};
            S_NEXT_CAND: w = '{op: OP_V_INC,     cond: C_AT_HI,        target: S_EMIT_WAIT};
            S_CAND_LP:   w = '{op: OP_NOP,       cond: C_ALWAYS,       target: S_CAND_INIT};
            S_EMIT_WAIT: w = '{op: OP_NOP,       cond: C_OUT_BUSY,     target: S_EMIT_WAIT};
            S_EMIT:      w = '{op: OP_EMIT,      cond: C_ALWAYS,       target: S_WAIT_IN};
            default:     w = '{op: OP_NOP,       cond: C_ALWAYS,       target: S_WAIT_IN};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### src/pcir_div.sv
`default_nettype none

// bit-serial restoring remainder, one dividend bit per cycle
module pcir_div #(
    parameter int VALUE_BITS = 16,
    parameter int DIV_BITS   = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [VALUE_BITS-1:0] i_dividend,
    input  wire logic [DIV_BITS-1:0]   i_divisor,
    output logic                       o_busy,
    output logic [DIV_BITS-1:0]        o_rem
);

    localparam int CW = $clog2(VALUE_BITS);

    logic                  r_busy, n_busy;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [VALUE_BITS-1:0] r_dvd, n_dvd;
    logic [DIV_BITS-1:0]   r_rem, n_rem;
    logic [DIV_BITS:0]     trial;

    assign trial = {r_rem, r_dvd[VALUE_BITS-1]};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(VALUE_BITS - 1);
            n_dvd  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[VALUE_BITS-2:0], 1'b0};
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = DIV_BITS'(trial - {1'b0, i_divisor});
            end else begin
                n_rem = trial[DIV_BITS-1:0];
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

### src/pcir_seq.sv
`default_nettype none

module pcir_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pcir_pkg::t_status i_status,
    output pcir_pkg::t_op         o_op,
    output logic                  o_idle
);

    pcir_pkg::t_pc    r_pc, n_pc;
    pcir_pkg::t_uword uw;
    logic             take;

    assign uw = pcir_pkg::ucode(r_pc);

    always_comb begin
        case (uw.cond)
            pcir_pkg::C_NONE:         take = 1'b0;
            pcir_pkg::C_ALWAYS:       take = 1'b1;
            pcir_pkg::C_NOT_IN_VALID: take = !i_status.in_valid;
            pcir_pkg::C_EMPTY:        take = i_status.empty;
            pcir_pkg::C_LT_TWO:       take = i_status.lt_two;
            pcir_pkg::C_SQ_GT:        take = i_status.sq_gt;
            pcir_pkg::C_DIV_BUSY:     take = i_status.div_busy;
            pcir_pkg::C_REM_ZERO:     take = i_status.rem_zero;
            pcir_pkg::C_AT_HI:        take = i_status.at_hi;
            pcir_pkg::C_OUT_BUSY:     take = i_status.out_busy;
            default:                  take = 1'b1;
        endcase
        n_pc = take ? uw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= pcir_pkg::S_WAIT_IN;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_op   = uw.op;
    assign o_idle = (r_pc == pcir_pkg::S_WAIT_IN);

endmodule

`default_nettype wire

### src/pcir_dp.sv
`default_nettype none

module pcir_dp #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire pcir_pkg::t_op                   i_op,
    input  wire logic                            i_in_valid,
    input  wire logic [VALUE_BITS-1:0]           i_range_low,
    input  wire logic [VALUE_BITS-1:0]           i_range_high,
    input  wire logic                            i_out_stall,
    output pcir_pkg::t_status                    o_status,
    output logic                                 o_out_valid,
    output logic [pcir_pkg::COUNT_BITS-1:0]      o_prime_count
);

    localparam int DW = VALUE_BITS / 2 + 2;
    localparam int SW = VALUE_BITS + 2;

    logic [VALUE_BITS-1:0]           r_v, r_hi;
    logic [DW-1:0]                   r_d;
    logic [SW-1:0]                   r_sq;
    logic [pcir_pkg::COUNT_BITS-1:0] r_cnt, r_out;
    logic                            r_out_valid;
    logic                            div_busy;
    logic [DW-1:0]                   div_rem;
    logic                            do_load;

    assign do_load = (i_op == pcir_pkg::OP_LOAD) && i_in_valid;

    pcir_div #(
        .VALUE_BITS(VALUE_BITS),
        .DIV_BITS  (DW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_op == pcir_pkg::OP_DIV_START),
        .i_dividend(r_v),
        .i_divisor (r_d),
        .o_busy    (div_busy),
        .o_rem     (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_v   <= i_range_low;
            r_hi  <= i_range_high;
            r_cnt <= '0;
        end
        case (i_op)
            pcir_pkg::OP_CAND_INIT: begin
                r_d  <= DW'(pcir_pkg::FIRST_DIVISOR);
                r_sq <= SW'(pcir_pkg::FIRST_DIVISOR * pcir_pkg::FIRST_DIVISOR);
            end
            pcir_pkg::OP_D_INC: begin
                r_d  <= r_d + 1'b1;
                r_sq <= r_sq + SW'({r_d, 1'b1});
            end
            pcir_pkg::OP_CNT_INC: r_cnt <= r_cnt + 1'b1;
            pcir_pkg::OP_V_INC:   r_v   <= r_v + 1'b1;
            pcir_pkg::OP_EMIT:    r_out <= r_cnt;
            default: ;
        endcase
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == pcir_pkg::OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_status.in_valid = i_in_valid;
        o_status.empty    = r_v > r_hi;
        o_status.lt_two   = r_v < VALUE_BITS'(pcir_pkg::FIRST_DIVISOR);
        o_status.sq_gt    = r_sq > SW'(r_v);
        o_status.div_busy = div_busy;
        o_status.rem_zero = (div_rem == '0);
        o_status.at_hi    = (r_v == r_hi);
        o_status.out_busy = r_out_valid && i_out_stall;
    end

    assign o_out_valid   = r_out_valid;
    assign o_prime_count = r_out;

endmodule

`default_nettype wire

### src/prime_count_in_range.sv
`default_nettype none

// Counts the primes in the inclusive range [range_low, range_high] by trial
// division (0 when low is above high) and returns one count per transaction.
// One query at a time: o_in_stall is low only while the block waits for a
// query; a finished count sits in an output register and the next query is
// taken while it waits. Each candidate is tried against the divisors 2 up to
// its square root, each remainder coming from the bit-serial remainder unit.
module prime_count_in_range #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [VALUE_BITS-1:0]           i_range_low,
    input  wire logic [VALUE_BITS-1:0]           i_range_high,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [pcir_pkg::COUNT_BITS-1:0]      o_prime_count
);

    pcir_pkg::t_op     op;
    pcir_pkg::t_status status;
    logic              idle;

    pcir_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_status(status),
        .o_op    (op),
        .o_idle  (idle)
    );

    pcir_dp #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_in_valid   (i_in_valid),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_out_stall  (i_out_stall),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_prime_count(o_prime_count)
    );

    assign o_in_stall = !idle;

endmodule

`default_nettype wire

### src/pcir_check.sv
`default_nettype none

module pcir_check #(
    parameter int VALUE_BITS = 16
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic [VALUE_BITS-1:0]           i_range_low,
    input wire logic [VALUE_BITS-1:0]           i_range_high,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic [pcir_pkg::COUNT_BITS-1:0] o_prime_count
);

    // a query in flight blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transaction");

    // a new count comes only out of a running query
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a running query");

    // the block is ready for a query as soon as it posts a count
    a_ready_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("input stalled when result posted");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_prime_count)))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=>
            (i_in_valid && $stable(i_range_low) && $stable(i_range_high)))
        else $error("stalled query changed");

endmodule

bind prime_count_in_range pcir_check #(
    .VALUE_BITS(VALUE_BITS)
) u_pcir_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_range_low  (i_range_low),
    .i_range_high (i_range_high),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_prime_count(o_prime_count)
);

`default_nettype wire

### verif/prime_count_in_range_test.sv
`timescale 1ns / 1ps

module prime_count_in_range_test;

    localparam int VALUE_BITS    = 16;
    localparam int CYCLE_LIMIT   = 30_000_000;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 18;
    localparam int MAX_VALUE     = (1 << VALUE_BITS) - 1;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [pcir_pkg::COUNT_BITS-1:0] t_count;

    typedef struct {
        t_value lo;
        t_value hi;
        bit     known;
        t_count count;
    } t_query_row;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_stall;
    t_value i_range_low;
    t_value i_range_high;
    logic   o_out_valid;
    logic   i_out_stall;
    t_count o_prime_count;

    t_count expected_counts[$];
    int     mismatches  = 0;
    int     cycle_count = 0;
    int     send_idle_pct;
    int     stall_pct;
    int     hold_asked  = 0;
    int     hold_taken  = 0;
    int     hold_left   = 0;

    t_query_row directed_queries[20] = '{
        '{16'd0,     16'd0,     1'b1, 17'd0},
        '{16'd1,     16'd1,     1'b1, 17'd0},
        '{16'd0,     16'd1,     1'b1, 17'd0},
        '{16'd2,     16'd2,     1'b1, 17'd1},
        '{16'd3,     16'd3,     1'b1, 17'd1},
        '{16'd4,     16'd4,     1'b1, 17'd0},
        '{16'd0,     16'd10,    1'b1, 17'd4},
        '{16'd0,     16'd100,   1'b1, 17'd25},
        '{16'd97,    16'd97,    1'b1, 17'd1},
        '{16'd65535, 16'd65535, 1'b1, 17'd0},
        '{16'd65521, 16'd65535, 1'b1, 17'd1},
        '{16'd65535, 16'd0,     1'b1, 17'd0},
        '{16'd65535, 16'd65534, 1'b1, 17'd0},
        '{16'd1,     16'd0,     1'b1, 17'd0},
        '{16'd100,   16'd97,    1'b1, 17'd0},
        '{16'd65519, 16'd65521, 1'b0, 17'd0},
        '{16'd32768, 16'd32800, 1'b0, 17'd0},
        '{16'd21845, 16'd21880, 1'b0, 17'd0},
        '{16'd43690, 16'd43720, 1'b0, 17'd0},
        '{16'd255,   16'd260,   1'b0, 17'd0}
    };

    prime_count_in_range #(
        .VALUE_BITS(VALUE_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_range_low(i_range_low),
        .i_range_high(i_range_high),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_prime_count(o_prime_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_count primes_between(input t_value lo, input t_value hi);
        int unsigned v;
        int unsigned d;
        int unsigned n;
        bit          prime;
        n = 0;
        if (lo <= hi) begin
            for (v = lo; v <= hi; v++) begin
                prime = (v >= pcir_pkg::FIRST_DIVISOR);
                for (d = pcir_pkg::FIRST_DIVISOR; prime && d * d <= v; d++) begin
                    if (v % d == 0)
                        prime = 1'b0;
                end
                if (prime)
                    n++;
            end
        end
        return t_count'(n);
    endfunction

    task automatic offer(input t_value lo, input t_value hi, input bit known,
                         input t_count count);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_range_low  <= lo;
        i_range_high <= hi;
        do @(posedge i_clk); while (o_in_stall);
        expected_counts.push_back(known ? count : primes_between(lo, hi));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_counts.size() != 0);
    endtask

    // receiver: random stall, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_asked != hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = hold_asked;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_count want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_counts.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, got %0d",
                         $time, o_prime_count);
                mismatches++;
            end else begin
                want = expected_counts.pop_front();
                if (o_prime_count !== want) begin
                    $display("%0t: prime_count mismatch, expected %0d, got %0d",
                             $time, want, o_prime_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout at %0t with %0d transactions outstanding",
                     $time, expected_counts.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int     i;
        int     phase;
        int     kind;
        int     top;
        t_value lo;
        t_value hi;
        int     send_pcts[4];
        int     stall_pcts[4];
        send_pcts  = '{0, 56, 0, 36};
        stall_pcts = '{0, 0, 56, 36};

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_range_low   = '0;
        i_range_high  = '0;
        i_out_stall   = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_queries[i])
            offer(directed_queries[i].lo, directed_queries[i].hi,
                  directed_queries[i].known, directed_queries[i].count);
        drain();

        // output held off while short queries keep coming: block backs up
        hold_asked++;
        for (i = 0; i < 5; i++) begin
            lo = t_value'($urandom_range(63));
            offer(lo, lo + t_value'($urandom_range(4)), 1'b0, '0);
        end
        drain();

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = send_pcts[phase];
            stall_pct     = stall_pcts[phase];
            for (i = 0; i < PHASE_ITEMS; i++) begin
                kind = $urandom_range(99);
                if (kind < 10) begin
                    hi = t_value'($urandom_range(MAX_VALUE - 1));
                    lo = t_value'($urandom_range(MAX_VALUE, int'(hi) + 1));
                end else if (kind < 30) begin
                    lo = t_value'($urandom_range(511));
                    hi = lo + t_value'($urandom_range(15));
                end else if (kind < 35) begin
                    lo = t_value'($urandom_range(2000));
                    hi = lo + t_value'($urandom_range(200));
                end else begin
                    lo  = t_value'($urandom);
                    top = int'(lo) + $urandom_range(15);
                    hi  = (top > MAX_VALUE) ? t_value'(MAX_VALUE) : t_value'(top);
                end
                offer(lo, hi, 1'b0, '0);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_counts.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### prime_count_in_range.f
src/pcir_pkg.sv
src/pcir_div.sv
src/pcir_seq.sv
src/pcir_dp.sv
src/prime_count_in_range.sv
src/pcir_check.sv
verif/prime_count_in_range_test.sv
